// ----- rtl/sha_pkg.sv -----
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_w;      // load message words from the block buffer
    logic start_round; // copy chaining value into working registers
    logic do_round;    // run one compression round
    logic add_cv;      // fold working registers into the chaining value
    logic reset_cv;    // restore the initial hash values
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic round_last;
  } dp_stat_t;

  localparam logic [31:0] InitialValue [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ----- rtl/sha_ifc.sv -----
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
  modport monitor (input valid, ready, data_byte, byte_present, end_of_message);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
  modport monitor (input valid, ready, digest_word, word_index, last_word);
endinterface

// ----- rtl/sha_datapath.sv -----
module sha_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::dp_cmd_t   cmd,
  input  logic [511:0]       block,
  input  logic [1:0]         word_sel,
  output sha_pkg::dp_stat_t  stat,
  output logic [63:0]        word_out
);

  logic [31:0] cv_r [8];
  logic [31:0] wk_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

  logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new;

  // One round of compression and one step of the message schedule.
  always_comb begin
    big1 = ror(wk_r[4], 6) ^ ror(wk_r[4], 11) ^ ror(wk_r[4], 25);
    ch = (wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]);
    t1 = wk_r[7] + big1 + ch + sha_pkg::RoundConst[rnd_r] + w_r[0];
    big0 = ror(wk_r[0], 2) ^ ror(wk_r[0], 13) ^ ror(wk_r[0], 22);
    maj = (wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]);
    t2 = big0 + maj;
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
  end

  // Chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_cv) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= sha_pkg::InitialValue[i];
    end else if (cmd.add_cv) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] + wk_r[i];
    end
  end

  // Working registers, schedule window and round counter.
  always_ff @(posedge clk) begin
    if (cmd.load_w) begin
      for (int i = 0; i < 16; i++) w_r[i] <= block[511 - 32*i -: 32];
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
    if (cmd.start_round) begin
      for (int i = 0; i < 8; i++) wk_r[i] <= cv_r[i];
    end else if (cmd.do_round) begin
      wk_r[0] <= t1 + t2;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= wk_r[1];
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[5] <= wk_r[4];
      wk_r[6] <= wk_r[5];
      wk_r[7] <= wk_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start_round) rnd_r <= '0;
    else if (cmd.do_round) rnd_r <= rnd_r + 6'd1;
  end

  assign stat.round_last = (rnd_r == 6'd63);
  assign word_out = {cv_r[{word_sel, 1'b0}], cv_r[{word_sel, 1'b1}]};

endmodule

// ----- rtl/sha_ctrl.sv -----
module sha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  sha_in_if.sink             in_ch,
  sha_out_if.source          out_ch,
  input  sha_pkg::dp_stat_t  stat,
  input  logic [63:0]        word_out,
  output sha_pkg::dp_cmd_t   cmd,
  output logic [511:0]       block,
  output logic [1:0]         word_sel
);

  sha_pkg::ctl_state_t state_r, state_nxt;
  logic [511:0] blk_r, blk_nxt;     // byte shift register, first byte ends on top
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  logic         fin_r, fin_nxt;     // finalization in progress
  logic         pad_r, pad_nxt;     // the pad byte is still owed
  logic         wrap_r, wrap_nxt;   // the length goes into the following block
  logic         done_r, done_nxt;   // the length has been shifted in
  logic [1:0]   widx_r, widx_nxt;
  logic         acc;
  logic         full;
  logic [7:0]   shift_byte;

  assign acc = in_ch.valid && in_ch.ready;
  assign full = in_ch.byte_present && (fill_r == 6'd63);
  assign block = blk_r;

  // Padding byte: the pad marker, then zero fill, then the length, high byte first.
  always_comb begin
    priority if (pad_r) shift_byte = sha_pkg::PadByte;
    else if (wrap_r || fill_r < sha_pkg::LengthPos) shift_byte = 8'h00;
    else shift_byte = len_r[63:56];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (acc && full) state_nxt = sha_pkg::ST_LOAD;
        else if (acc && in_ch.end_of_message) state_nxt = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_PAD: if (fill_r == 6'd63) state_nxt = sha_pkg::ST_LOAD;
      sha_pkg::ST_LOAD: state_nxt = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (stat.round_last) state_nxt = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (!fin_r) state_nxt = sha_pkg::ST_IDLE;
        else if (done_r) state_nxt = sha_pkg::ST_EMIT;
        else state_nxt = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_EMIT: if (out_ch.ready && widx_r == 2'd3) state_nxt = sha_pkg::ST_IDLE;
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ch.ready = (state_r == sha_pkg::ST_IDLE);
    out_ch.valid = (state_r == sha_pkg::ST_EMIT);
    unique case (state_r)
      sha_pkg::ST_LOAD: begin
        cmd.load_w = 1'b1;
        cmd.start_round = 1'b1;
      end
      sha_pkg::ST_ROUND: cmd.do_round = 1'b1;
      sha_pkg::ST_ADD: cmd.add_cv = 1'b1;
      sha_pkg::ST_EMIT: cmd.reset_cv = out_ch.ready && widx_r == 2'd3;
      default: ;
    endcase
  end

  assign word_sel = widx_r;
  assign out_ch.digest_word = word_out;
  assign out_ch.word_index = widx_r;
  assign out_ch.last_word = (widx_r == 2'd3);

  // Byte buffer, fill count, length and finalization flags.
  always_comb begin
    blk_nxt = blk_r;
    fill_nxt = fill_r;
    len_nxt = len_r;
    fin_nxt = fin_r;
    pad_nxt = pad_r;
    wrap_nxt = wrap_r;
    done_nxt = done_r;
    widx_nxt = widx_r;
    unique case (state_r)
      sha_pkg::ST_IDLE: begin
        if (acc && in_ch.byte_present) begin
          blk_nxt = {blk_r[503:0], in_ch.data_byte};
          fill_nxt = fill_r + 6'd1;
          len_nxt = len_r + 64'd8;
        end
        if (acc && in_ch.end_of_message) begin
          fin_nxt = 1'b1;
          pad_nxt = 1'b1;
        end
      end
      sha_pkg::ST_PAD: begin
        blk_nxt = {blk_r[503:0], shift_byte};
        fill_nxt = fill_r + 6'd1;
        if (pad_r) begin
          pad_nxt = 1'b0;
          wrap_nxt = (fill_r >= sha_pkg::LengthPos);
        end else if (!wrap_r && fill_r >= sha_pkg::LengthPos) begin
          len_nxt = {len_r[55:0], 8'h00};
          done_nxt = (fill_r == 6'd63);
        end
      end
      sha_pkg::ST_ADD: begin
        wrap_nxt = 1'b0;
        if (done_r) begin
          fin_nxt = 1'b0;
          done_nxt = 1'b0;
        end
      end
      sha_pkg::ST_EMIT: if (out_ch.ready) widx_nxt = widx_r + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      fill_r <= '0;
      len_r <= '0;
      fin_r <= 1'b0;
      pad_r <= 1'b0;
      wrap_r <= 1'b0;
      done_r <= 1'b0;
      widx_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      len_r <= len_nxt;
      fin_r <= fin_nxt;
      pad_r <= pad_nxt;
      wrap_r <= wrap_nxt;
      done_r <= done_nxt;
      widx_r <= widx_nxt;
    end
  end

  // The block contents need no reset; every byte is written before it is hashed.
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == sha_pkg::ST_IDLE) else $error("ready outside idle");
  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_word |=> state_r == sha_pkg::ST_IDLE)
    else $error("digest did not end");
  a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha_pkg::ST_EMIT |-> !fin_r && fill_r == 6'd0 && len_r == 64'd0)
    else $error("emit too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word)
    && $stable(out_ch.word_index)) else $error("digest item changed while stalled");

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// SHA-256 hasher over a byte stream.
// Input channel (in_): one item per cycle at most; each item may carry one
// message byte (byte_present) and may close the message (end_of_message).
// Result channel (out_): after a closing item the digest leaves as four
// 64-bit items, word_index 0 (most significant) to 3, last_word on index 3.
// Input stays ready after a byte that does not fill the 64-byte block.
// Filling a block runs the compression, one round per cycle through a
// single round unit; no item is accepted while it runs.
// Closing a message shifts the pad byte, zero fill and length into the
// block one byte per cycle (64 bytes minus the fill count, and 64 more when
// the length needs a second block), with a compression after each block;
// all of this comes before the first digest item.
// The four digest items then leave one per cycle while the receiver is ready.
// A stalled receiver holds the current digest item; input stays blocked
// until the last digest word is taken, and the block then restarts with
// the initial hash values and a zero length.
// Reset (rst_n low, synchronous) returns to idle with the initial hash
// values, an empty buffer and a zero bit length.
module sha256_stream_hasher (
  input logic       clk,
  input logic       rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::dp_cmd_t  cmd;
  sha_pkg::dp_stat_t stat;
  logic [511:0] block;
  logic [63:0]  word_out;
  logic [1:0]   word_sel;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .stat(stat), .word_out(word_out), .cmd(cmd), .block(block), .word_sel(word_sel)
  );

  sha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .block(block), .word_sel(word_sel),
    .stat(stat), .word_out(word_out)
  );

endmodule
